FILE: rtl/dfs_pkg.sv
// Shared types and constants of the delimited field splitter.
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int OUT_BITS = 32;
  localparam int COL_BITS = 8;
  localparam int COLCNT_BITS = 9;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int TRIM_SLOTS = 4;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_DELIM = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_DELIM = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIM_CHARS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIM_COUNT = 2'd3;

  localparam logic [7:0] COLUMN_DELIM_RESET = 8'd44;
  localparam logic [7:0] ROW_DELIM_RESET = 8'd10;

  typedef struct packed {
    logic [7:0] column_delim;
    logic [7:0] row_delim;
    logic [31:0] trim_chars;
    logic [2:0] trim_count;
  } cfg_regs_t;

  typedef struct packed {
    logic is_row;
    logic is_column;
    logic is_trim;
  } byte_class_t;

endpackage

FILE: rtl/delimited_field_splitter_core.sv
// Top level of the delimited field splitter: input register, field tracking, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall  req_type, data_byte
// out       from block out_valid / out_stall field_offset, field_length, column_number,
//                                           row_end, row_ok
// cfg       to block   cfg_write_en         cfg_index, cfg_data
//
// Every word passes through the field tracker; a new word is accepted in every cycle unless in_stall is high.
// A word is held in the input register, and its result is written into the result register when
// the word moves on; the output handshake is made from the result register.
// The rate is set by the single stage between the input register and the result register.
// in_stall rises only while a word waits in the input register and the result register is
// held by out_stall. Reset (rst, synchronous) empties both registers and restores the
// register defaults and the stream state.

module delimited_field_splitter_core import dfs_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int OFFSET_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [7:0]                data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_BITS-1:0]       field_offset,
  output logic [OUT_BITS-1:0]       field_length,
  output logic [COL_BITS-1:0]       column_number,
  output logic                      row_end,
  output logic                      row_ok,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int WIDE_BITS = (OFFSET_BITS > OUT_BITS) ? OFFSET_BITS : OUT_BITS;
  localparam logic [COLCNT_BITS-1:0] FIRST_ROW_LIMIT = COLCNT_BITS'(MAX_COLUMNS);

  // Configuration registers.
  cfg_regs_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_delim <= COLUMN_DELIM_RESET;
      cfg.row_delim <= ROW_DELIM_RESET;
      cfg.trim_chars <= '0;
      cfg.trim_count <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_COLUMN_DELIM: cfg.column_delim <= cfg_data[7:0];
        CFG_ROW_DELIM:    cfg.row_delim <= cfg_data[7:0];
        CFG_TRIM_CHARS:   cfg.trim_chars <= cfg_data;
        CFG_TRIM_COUNT:   cfg.trim_count <= cfg_data[2:0];
        default:          cfg.trim_count <= cfg.trim_count;
      endcase
    end
  end

  // Input register. It takes a word whenever it is empty or its word moves on this cycle.
  logic       in_full;
  logic       in_req;
  logic [7:0] in_byte;
  logic       advance;

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req <= req_type;
      in_byte <= data_byte;
    end
  end

  byte_class_t cls;

  dfs_classify u_classify (
    .data_byte (in_byte),
    .cfg       (cfg),
    .cls       (cls)
  );

  // Stream state.
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] field_begin, field_begin_next;
  logic [OFFSET_BITS-1:0] first_kept, first_kept_next;
  logic [OFFSET_BITS-1:0] last_kept, last_kept_next;
  logic                   kept_seen, kept_seen_next;
  logic [COL_BITS-1:0]    current_column, current_column_next;
  logic [COLCNT_BITS-1:0] columns_fixed, columns_fixed_next;
  logic                   in_first_row, in_first_row_next;
  logic                   any_byte, any_byte_next;

  // Result of the word in the input register.
  logic                   produce;
  logic                   res_row_end;
  logic                   res_row_ok;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [OFFSET_BITS-1:0] res_length;

  logic [COLCNT_BITS-1:0] column_plus_one;
  logic [COLCNT_BITS-1:0] column_limit;
  logic                   split;
  logic                   closes_row;

  assign column_plus_one = {1'b0, current_column} + COLCNT_BITS'(1);
  assign column_limit = in_first_row ? FIRST_ROW_LIMIT : columns_fixed;
  // A row delimiter wins over a column delimiter of the same value.
  assign split = (in_req == REQ_DATA) && !cls.is_row && cls.is_column &&
                 (column_plus_one < column_limit);
  // End of input closes the pending row only if the stream has carried a byte.
  assign closes_row = (in_req == REQ_DATA) ? cls.is_row : any_byte;

  assign produce = closes_row || split;
  assign res_row_end = closes_row;
  assign res_row_ok = closes_row && (in_first_row || (column_plus_one >= columns_fixed));
  // An empty trimmed field reports where the untrimmed field began.
  assign res_offset = kept_seen ? first_kept : field_begin;
  assign res_length = kept_seen ? (last_kept - first_kept + OFFSET_BITS'(1)) : '0;

  always_comb begin
    byte_position_next = byte_position;
    field_begin_next = field_begin;
    first_kept_next = first_kept;
    last_kept_next = last_kept;
    kept_seen_next = kept_seen;
    current_column_next = current_column;
    columns_fixed_next = columns_fixed;
    in_first_row_next = in_first_row;
    any_byte_next = any_byte;
    if (in_req == REQ_END) begin
      // A new stream begins after the end of input.
      byte_position_next = '0;
      field_begin_next = '0;
      first_kept_next = '0;
      last_kept_next = '0;
      kept_seen_next = 1'b0;
      current_column_next = '0;
      columns_fixed_next = '0;
      in_first_row_next = 1'b1;
      any_byte_next = 1'b0;
    end else begin
      any_byte_next = 1'b1;
      byte_position_next = byte_position + OFFSET_BITS'(1);
      if (cls.is_row) begin
        if (in_first_row) begin
          columns_fixed_next = column_plus_one;
          in_first_row_next = 1'b0;
        end
        current_column_next = '0;
        field_begin_next = byte_position + OFFSET_BITS'(1);
        kept_seen_next = 1'b0;
      end else if (split) begin
        current_column_next = column_plus_one[COL_BITS-1:0];
        field_begin_next = byte_position + OFFSET_BITS'(1);
        kept_seen_next = 1'b0;
      end else if (!cls.is_trim) begin
        if (!kept_seen) begin
          first_kept_next = byte_position;
          kept_seen_next = 1'b1;
        end
        last_kept_next = byte_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      field_begin <= '0;
      first_kept <= '0;
      last_kept <= '0;
      kept_seen <= 1'b0;
      current_column <= '0;
      columns_fixed <= '0;
      in_first_row <= 1'b1;
      any_byte <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      field_begin <= field_begin_next;
      first_kept <= first_kept_next;
      last_kept <= last_kept_next;
      kept_seen <= kept_seen_next;
      current_column <= current_column_next;
      columns_fixed <= columns_fixed_next;
      in_first_row <= in_first_row_next;
      any_byte <= any_byte_next;
    end
  end

  // Result register. Offsets and lengths are reported in their low 32 bits.
  logic [WIDE_BITS-1:0] offset_wide;
  logic [WIDE_BITS-1:0] length_wide;

  assign offset_wide = WIDE_BITS'(res_offset);
  assign length_wide = WIDE_BITS'(res_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      field_offset <= offset_wide[OUT_BITS-1:0];
      field_length <= length_wide[OUT_BITS-1:0];
      column_number <= current_column;
      row_end <= res_row_end;
      row_ok <= res_row_ok;
    end
  end

`ifndef SYNTH
  // A stall toward the input only comes from a word waiting in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> in_full)
    else $error("input stalled with an empty input register");

  // Only a row end can report a complete row.
  assert property (@(posedge clk) disable iff (rst) out_valid && row_ok |-> row_end)
    else $error("row_ok set on a field that does not end its row");

  // A field closed by a column delimiter always leaves room for one more column.
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !row_end |-> ({1'b0, column_number} + COLCNT_BITS'(1)) < FIRST_ROW_LIMIT)
    else $error("column split beyond the column limit");

  // Once the first row has closed, the column count is fixed and in range.
  assert property (@(posedge clk) disable iff (rst)
      !in_first_row |-> (columns_fixed != '0) && (columns_fixed <= FIRST_ROW_LIMIT))
    else $error("fixed column count out of range");

  // An end of input on a stream without bytes gives no result.
  assert property (@(posedge clk) disable iff (rst)
      advance && (in_req == REQ_END) && !any_byte |=> !out_valid)
    else $error("result emitted for an empty stream");
`endif

endmodule

FILE: rtl/dfs_classify.sv
// Byte classifier: matches a text byte against the delimiters and trim bytes.
`timescale 1ns / 1ps

module dfs_classify import dfs_pkg::*; (
  input  logic [7:0]  data_byte,
  input  cfg_regs_t   cfg,
  output byte_class_t cls
);

  logic [TRIM_SLOTS-1:0] trim_hit;

  // A trim count above four enables all four slots.
  always_comb begin
    for (int i = 0; i < TRIM_SLOTS; i++) begin
      trim_hit[i] = (cfg.trim_count > 3'(i)) && (cfg.trim_chars[8*i +: 8] == data_byte);
    end
  end

  assign cls.is_row = (data_byte == cfg.row_delim);
  assign cls.is_column = (data_byte == cfg.column_delim);
  assign cls.is_trim = |trim_hit;

endmodule

FILE: verif/delimited_field_splitter_core_tb.sv
// Self-checking testbench for the delimited field splitter core, with a field-level scoreboard.
`timescale 1ns / 1ps

module delimited_field_splitter_core_tb import dfs_pkg::*; ();

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] len;
    logic [7:0]  col;
    logic        row_end;
    logic        row_ok;
  } field_t;

  // Tracks the splitter's registers and stream state, predicts the field that each
  // accepted word closes, and checks every field that leaves the block.
  class field_scoreboard #(int COLUMN_LIMIT = 256);
    logic [7:0]  col_delim;
    logic [7:0]  row_delim;
    logic [31:0] trim_bytes;
    logic [2:0]  trim_used;

    logic [31:0] pos;
    logic [31:0] begin_pos;
    logic [31:0] kept_first;
    logic [31:0] kept_last;
    logic        kept_any;
    logic [7:0]  column;
    logic [8:0]  col_total;
    logic        first_row;
    logic        got_byte;

    field_t fields_due[$];
    int     errors;

    function new();
      col_delim  = COLUMN_DELIM_RESET;
      row_delim  = ROW_DELIM_RESET;
      trim_bytes = '0;
      trim_used  = '0;
      errors     = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      pos        = '0;
      begin_pos  = '0;
      kept_first = '0;
      kept_last  = '0;
      kept_any   = 1'b0;
      column     = '0;
      col_total  = '0;
      first_row  = 1'b1;
      got_byte   = 1'b0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_COLUMN_DELIM: col_delim = data[7:0];
        CFG_ROW_DELIM:    row_delim = data[7:0];
        CFG_TRIM_CHARS:   trim_bytes = data;
        CFG_TRIM_COUNT:   trim_used = data[2:0];
        default: ;
      endcase
    endfunction

    function bit is_trim(logic [7:0] b);
      int slots;
      slots = (trim_used > 4) ? 4 : int'(trim_used);
      for (int i = 0; i < slots; i++)
        if (trim_bytes[8*i +: 8] == b) return 1'b1;
      return 1'b0;
    endfunction

    function field_t make_field(logic last, logic ok);
      field_t f;
      if (kept_any) begin
        f.off = kept_first;
        f.len = kept_last - kept_first + 32'd1;
      end else begin
        f.off = begin_pos;
        f.len = '0;
      end
      f.col     = column;
      f.row_end = last;
      f.row_ok  = ok;
      return f;
    endfunction

    // A row is short when a later row closes before reaching the first row's count.
    function void close_row();
      logic ok;
      ok = first_row || ({1'b0, column} + 9'd1 >= col_total);
      fields_due = {fields_due, make_field(1'b1, ok)};
      if (first_row) begin
        col_total = {1'b0, column} + 9'd1;
        first_row = 1'b0;
      end
      column = '0;
    endfunction

    function void note_input(logic kind, logic [7:0] b);
      bit split;
      int limit;
      if (kind == REQ_END) begin
        if (got_byte) close_row();
        clear_stream();
        return;
      end
      got_byte = 1'b1;
      if (b == row_delim) begin
        close_row();
        begin_pos = pos + 32'd1;
        kept_any  = 1'b0;
      end else begin
        split = 1'b0;
        if (b == col_delim) begin
          limit = first_row ? COLUMN_LIMIT : int'(col_total);
          split = (int'(column) + 1 < limit);
        end
        if (split) begin
          fields_due = {fields_due, make_field(1'b0, 1'b0)};
          column    = column + 8'd1;
          begin_pos = pos + 32'd1;
          kept_any  = 1'b0;
        end else if (!is_trim(b)) begin
          if (!kept_any) begin
            kept_first = pos;
            kept_any   = 1'b1;
          end
          kept_last = pos;
        end
      end
      pos = pos + 32'd1;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_value(string name, logic [31:0] seen, logic [31:0] want);
      if (seen !== want)
        report($sformatf("%s is %0h, expected %0h", name, seen, want));
    endtask

    task check_result(field_t got);
      field_t want;
      if (fields_due.size() == 0) begin
        report($sformatf("field with nothing expected: column %0d offset %0d",
                         got.col, got.off));
        return;
      end
      want = fields_due.pop_front();
      check_value("field_offset", got.off, want.off);
      check_value("field_length", got.len, want.len);
      check_value("column_number", 32'(got.col), 32'(want.col));
      check_value("row_end", 32'(got.row_end), 32'(want.row_end));
      check_value("row_ok", 32'(got.row_ok), 32'(want.row_ok));
    endtask
  endclass

  localparam int COLUMN_LIMIT  = 256;
  localparam int CYCLE_LIMIT   = 400000;
  // Margin after the last expected field for words that close no field but are still in flight.
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PCT      = 32;
  localparam int PHASE_WORDS   = 165;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      req_type;
  logic [7:0]                data_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_BITS-1:0]       field_offset;
  logic [OUT_BITS-1:0]       field_length;
  logic [COL_BITS-1:0]       column_number;
  logic                      row_end;
  logic                      row_ok;
  logic                      cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  field_scoreboard #(COLUMN_LIMIT) sb;
  field_t seen_field;
  int     cycle_count = 0;
  int     words_sent;
  // While calm is set neither side idles, giving one long back-to-back stretch.
  bit     calm;

  delimited_field_splitter_core #(
    .MAX_COLUMNS(COLUMN_LIMIT),
    .OFFSET_BITS(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .field_offset(field_offset),
    .field_length(field_length),
    .column_number(column_number),
    .row_end(row_end),
    .row_ok(row_ok),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[delimited_field_splitter_core] ERROR");
      $finish;
    end
  end

  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_field.off     = field_offset;
      seen_field.len     = field_length;
      seen_field.col     = column_number;
      seen_field.row_end = row_end;
      seen_field.row_ok  = row_ok;
      sb.check_result(seen_field);
    end
  end

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Offers one word, possibly after a few idle cycles, and holds it until it is taken.
  // Entered and left just after a falling edge, so valid is assigned once per step.
  task automatic send_word(logic kind, logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(kind, b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(REQ_DATA, s[i]);
  endtask

  // Holds the sender back until every expected field is out and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.fields_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers change only with the block idle. Unused upper data bits carry random junk.
  task automatic set_config(logic [7:0] cd, logic [7:0] rd, logic [31:0] chars,
                            logic [2:0] count);
    drain();
    write_reg(CFG_COLUMN_DELIM, (32'($urandom) & 32'hFFFF_FF00) | 32'(cd));
    write_reg(CFG_ROW_DELIM, (32'($urandom) & 32'hFFFF_FF00) | 32'(rd));
    write_reg(CFG_TRIM_CHARS, chars);
    write_reg(CFG_TRIM_COUNT, (32'($urandom) & 32'hFFFF_FFF8) | 32'(count));
    cfg_write_en <= 1'b0;
  endtask

  // Mostly ordinary text, some trim bytes to exercise trimming at both ends, and a
  // little raw noise that may hit a delimiter.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    int roll;
    int slots;
    roll  = $urandom_range(99);
    slots = (sb.trim_used > 4) ? 4 : int'(sb.trim_used);
    if (roll < 5) return 8'($urandom);
    if (roll < 25 && slots > 0) return sb.trim_bytes[8*$urandom_range(slots-1) +: 8];
    do b = 8'($urandom); while (b == sb.col_delim || b == sb.row_delim);
    return b;
  endfunction

  // One row, usually with the intended column count, sometimes short or long.
  // A few rows end on end of input instead of the row delimiter.
  task automatic send_row(int ncols, output bit ended);
    int roll;
    int nfields;
    int nbytes;
    int f;
    int k;
    roll = $urandom_range(99);
    if (roll < 75) nfields = ncols;
    else if (roll < 88) nfields = $urandom_range(ncols, 1);
    else nfields = ncols + $urandom_range(3, 1);
    for (f = 0; f < nfields; f++) begin
      nbytes = $urandom_range(6);
      for (k = 0; k < nbytes; k++) send_word(REQ_DATA, text_byte());
      if (f < nfields - 1) send_word(REQ_DATA, sb.col_delim);
    end
    ended = ($urandom_range(99) < 6);
    if (ended) send_word(REQ_END, 8'($urandom));
    else send_word(REQ_DATA, sb.row_delim);
  endtask

  task automatic run_phase(int quota);
    int  stop;
    int  ncols;
    bit  ended;
    stop  = words_sent + quota;
    ncols = $urandom_range(5, 1);
    while (words_sent < stop) begin
      send_row(ncols, ended);
      if (!ended && $urandom_range(99) < 12) begin
        send_word(REQ_END, 8'($urandom));
        ended = 1'b1;
      end
      if (ended) begin
        // An end of input on an empty stream must produce nothing.
        if ($urandom_range(99) < 15) send_word(REQ_END, 8'($urandom));
        ncols = $urandom_range(5, 1);
      end
    end
  endtask

  initial begin
    logic [7:0] cd;
    logic [7:0] rd;
    int i;
    int ph;

    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_DATA;
    data_byte    = '0;
    out_stall    = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_COLUMN_DELIM;
    cfg_data     = '0;
    calm         = 1'b0;
    words_sent   = 0;
    sb = new();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed start on reset registers: comma and newline, no trimming.
    // End of input on a stream that has seen nothing gives no field.
    send_word(REQ_END, 8'hFF);
    // First row fixes two columns; the data bytes reach both extremes.
    send_word(REQ_DATA, 8'h00);
    send_text(",");
    send_word(REQ_DATA, 8'hFF);
    send_text("\n");
    // A short row, then a long one whose extra comma stays in the last field.
    send_text("x\n");
    send_text("p,q,r\n");
    // An empty row, and the end of input closes one more empty row behind it.
    send_text("\n");
    send_word(REQ_END, 8'h00);

    // Both delimiters equal, so every one of them ends the row. All four trim slots
    // are in use and a count above four must behave as four.
    set_config(8'h3B, 8'h3B, 32'h5F2E_0920, 3'd7);
    // A field trimmed at both ends, then one trimmed to nothing, then a row closed
    // by end of input with no row delimiter.
    send_text(" a\t;  .;_b");
    send_word(REQ_END, 8'h5A);

    // Overflow of the column limit in the first row: past the limit, column
    // delimiters stay in the last field. The second row just fills the count,
    // the third falls short.
    set_config(8'd44, 8'd10, 32'h0, 3'd0);
    for (i = 0; i < COLUMN_LIMIT + 4; i++) send_word(REQ_DATA, sb.col_delim);
    send_text("xy\n");
    for (i = 0; i < COLUMN_LIMIT + 1; i++) send_word(REQ_DATA, sb.col_delim);
    send_text("\na,b\n");
    send_word(REQ_END, 8'h00);

    // Random phases, each on a fresh register setting and each started from a fully
    // drained block. The first three settings take the extremes.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(8'd44, 8'd10, 32'h0000_0020, 3'd1);
        1: set_config(8'h00, 8'hFF, 32'hFFFF_FFFF, 3'd4);
        2: set_config(8'hFF, 8'h00, 32'h0000_0000, 3'd0);
        default: begin
          cd = 8'($urandom);
          rd = ($urandom_range(3) == 0) ? cd : 8'($urandom);
          set_config(cd, rd, 32'($urandom), 3'($urandom_range(7)));
        end
      endcase
      calm = (ph == 2);
      run_phase(PHASE_WORDS);
    end
    calm = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("[delimited_field_splitter_core] OK");
    end else begin
      $display("[delimited_field_splitter_core] ERROR");
    end
    $finish;
  end

endmodule
